>>> sv/dstq_pkg.sv
// Shared types and constants for the deadline-sorted timer queue.
`timescale 1ns / 1ps
package dstq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 48;
  localparam int HANDLE_BITS = 16;

  // index into the stores, and a count that can hold the depth itself
  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  // second entry of the stores, clipped for a single-entry queue
  localparam int IDX_ONE = (QUEUE_DEPTH > 1) ? 1 : 0;

  typedef logic [TIME_BITS-1:0]   time_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_FULL     = 2'd1,
    ST_FIRED    = 2'd2,
    ST_NONE_DUE = 2'd3
  } status_t;

  typedef enum logic {
    ACT_ENQUEUE = 1'b0,
    ACT_TICK    = 1'b1
  } action_t;

  // controller to datapath
  typedef struct packed {
    logic    load;       // latch the accepted word and start the insert index
    logic    ins_shift;  // move the entry below the insert point up by one
    logic    ins_write;  // place the new entry at the insert point
    logic    pop;        // drop the head entry, shift the rest down
    logic    out_load;   // register a result word
    status_t status;     // kind of result being registered
  } dstq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;      // no room for another entry
    logic ins_done;  // insert point found
    logic head_due;  // head entry expires before the present time
    logic next_due;  // second entry expires too
  } dstq_stat_t;

endpackage

>>> sv/dstq_in_if.sv
// Input channel: enqueue and tick words.
`timescale 1ns / 1ps
interface dstq_in_if;
  import dstq_pkg::*;

  logic    valid;
  logic    ready;
  action_t action;
  time_t   deadline;
  handle_t handle;
  time_t   current_time;

  modport source (output valid, output action, output deadline, output handle,
                  output current_time, input ready);
  modport sink   (input valid, input action, input deadline, input handle,
                  input current_time, output ready);
endinterface

>>> sv/dstq_out_if.sv
// Result channel: status words from the timer queue.
`timescale 1ns / 1ps
interface dstq_out_if;
  import dstq_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  handle_t fired_handle;
  logic    last;
  cnt_t    pending_count;

  modport source (output valid, output status, output fired_handle, output last,
                  output pending_count, input ready);
  modport sink   (input valid, input status, input fired_handle, input last,
                  input pending_count, output ready);
endinterface

>>> sv/dstq_ctrl.sv
// Sequencer for insertion and draining of the timer queue.
`timescale 1ns / 1ps
module dstq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  dstq_pkg::action_t   in_action,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  dstq_pkg::dstq_stat_t stat,
  output dstq_pkg::dstq_cmd_t cmd
);
  import dstq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INSERT,
    S_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // decide the step for this cycle
  always_comb begin
    cmd       = '0;
    cmd.status = ST_ENQUEUED;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_action == ACT_TICK) ? S_DRAIN : S_INSERT;
        end
      end
      S_INSERT: begin
        if (!stat.ins_done) begin
          cmd.ins_shift = 1'b1;
        end else if (out_free) begin
          cmd.out_load  = 1'b1;
          cmd.status    = stat.full ? ST_FULL : ST_ENQUEUED;
          cmd.ins_write = !stat.full;
          state_nxt     = S_IDLE;
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          if (stat.head_due) begin
            cmd.status = ST_FIRED;
            cmd.pop    = 1'b1;
            if (!stat.next_due) begin
              state_nxt = S_IDLE;
            end
          end else begin
            cmd.status = ST_NONE_DUE;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // hold a result until the sink takes it
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result word overwritten while stalled");

  // an accepted word always starts work
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r != S_IDLE))
    else $error("accepted word did not start a sequence");

  // a pop is only issued alongside a fired result
  a_pop_fired: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (cmd.out_load && cmd.status == ST_FIRED))
    else $error("pop without a fired result");
`endif

endmodule

>>> sv/dstq_datapath.sv
// Entry stores, entry count, deadline compares and result register.
`timescale 1ns / 1ps
module dstq_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dstq_pkg::dstq_cmd_t  cmd,
  output dstq_pkg::dstq_stat_t stat,
  input  dstq_pkg::time_t      in_deadline,
  input  dstq_pkg::handle_t    in_handle,
  input  dstq_pkg::time_t      in_current_time,
  output dstq_pkg::status_t    out_status,
  output dstq_pkg::handle_t    out_fired_handle,
  output logic                 out_last,
  output dstq_pkg::cnt_t       out_pending_count
);
  import dstq_pkg::*;

  time_t   dl_store_r [QUEUE_DEPTH];
  handle_t hd_store_r [QUEUE_DEPTH];
  cnt_t    count_r, count_nxt;
  idx_t    idx_r;
  idx_t    idx_m1;
  time_t   item_dl_r;
  handle_t item_hd_r;
  time_t   item_now_r;

  status_t res_status_r;
  handle_t res_handle_r;
  logic    res_last_r;
  cnt_t    res_pending_r;

  handle_t res_handle_nxt;
  logic    res_last_nxt;
  cnt_t    res_pending_nxt;

  time_t   rd_dl;
  handle_t rd_hd;

  assign idx_m1 = idx_r - idx_t'(1);
  assign rd_dl  = dl_store_r[idx_m1];
  assign rd_hd  = hd_store_r[idx_m1];

  // compare against the entry below the insert point and the two head entries
  assign stat.full     = (count_r == cnt_t'(QUEUE_DEPTH));
  assign stat.ins_done = stat.full || (idx_r == '0) || !(rd_dl > item_dl_r);
  assign stat.head_due = (count_r != '0) && (dl_store_r[0] < item_now_r);
  assign stat.next_due = (count_r > cnt_t'(1)) && (dl_store_r[IDX_ONE] < item_now_r);

  // shape the result word for this step
  always_comb begin
    res_handle_nxt  = '0;
    res_last_nxt    = 1'b1;
    res_pending_nxt = count_r;
    unique case (cmd.status)
      ST_ENQUEUED: res_pending_nxt = count_r + cnt_t'(1);
      ST_FULL:     res_pending_nxt = count_r;
      ST_FIRED: begin
        res_handle_nxt  = hd_store_r[0];
        res_last_nxt    = !stat.next_due;
        res_pending_nxt = count_r - cnt_t'(1);
      end
      ST_NONE_DUE: res_pending_nxt = count_r;
      default:     res_pending_nxt = count_r;
    endcase
  end

  // track the number of queued entries
  always_comb begin
    priority if (cmd.ins_write) begin
      count_nxt = count_r + cnt_t'(1);
    end else if (cmd.pop) begin
      count_nxt = count_r - cnt_t'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // latch the accepted word and step the insert index downwards
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_dl_r  <= in_deadline;
      item_hd_r  <= in_handle;
      item_now_r <= in_current_time;
      idx_r      <= count_r[IDX_W-1:0];
    end else if (cmd.ins_shift) begin
      idx_r <= idx_m1;
    end
  end

  // move entries: open a slot, fill it, or drop the head
  always_ff @(posedge clk) begin
    if (cmd.ins_shift) begin
      dl_store_r[idx_r] <= rd_dl;
      hd_store_r[idx_r] <= rd_hd;
    end else if (cmd.ins_write) begin
      dl_store_r[idx_r] <= item_dl_r;
      hd_store_r[idx_r] <= item_hd_r;
    end else if (cmd.pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        dl_store_r[i] <= dl_store_r[i+1];
        hd_store_r[i] <= hd_store_r[i+1];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_status_r  <= cmd.status;
      res_handle_r  <= res_handle_nxt;
      res_last_r    <= res_last_nxt;
      res_pending_r <= res_pending_nxt;
    end
  end

  assign out_status        = res_status_r;
  assign out_fired_handle  = res_handle_r;
  assign out_last          = res_last_r;
  assign out_pending_count = res_pending_r;

`ifndef SYNTHESIS
  // the count never passes the depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  // no pop from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (count_r != '0))
    else $error("pop from empty queue");

  // a fill into a full queue never happens
  a_write_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_write |-> !stat.full)
    else $error("insert into full queue");
`endif

endmodule

>>> sv/deadline_sorted_timer_queue.sv
// Top level of the deadline-sorted timer queue.
//
//   channel  dir  handshake     word
//   in_chan  in   valid/ready   action, deadline, handle, current_time
//   out_chan out  valid/ready   status, fired_handle, last, pending_count
//
// An enqueue's insert scan walks one entry a cycle down from the tail past
// the N entries with a later deadline, through a single deadline compare;
// a full queue skips the scan. A tick gives one fired word a cycle off the
// head compare while no result stalls, or one none-due word. Reset clears
// the sequencer state, the result valid and the entry count; the stores
// need no clearing pass. A stalled result holds the sequence at its next
// word; a new word is taken once the previous sequence has finished.
`timescale 1ns / 1ps
module deadline_sorted_timer_queue (
  input  logic       clk,
  input  logic       rst_n,
  dstq_in_if.sink    in_chan,
  dstq_out_if.source out_chan
);
  import dstq_pkg::*;

  dstq_cmd_t  cmd;
  dstq_stat_t stat;

  dstq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_action (in_chan.action),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  dstq_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_deadline       (in_chan.deadline),
    .in_handle         (in_chan.handle),
    .in_current_time   (in_chan.current_time),
    .out_status        (out_chan.status),
    .out_fired_handle  (out_chan.fired_handle),
    .out_last          (out_chan.last),
    .out_pending_count (out_chan.pending_count)
  );

endmodule

>>> bench/tb_deadline_sorted_timer_queue.sv
// Self-checking bench for the deadline-sorted timer queue: shadow queue, driver and monitor.
`timescale 1ns / 1ps
module tb_deadline_sorted_timer_queue;
  import dstq_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no word moving on either channel
  localparam int DRAIN_WAIT  = 24;    // longest enqueue scan plus margin
  localparam int N_RANDOM    = 194;

  typedef struct {
    action_t action;
    time_t   deadline;
    handle_t handle;
    time_t   at_time;
    bit      hold;      // sender waits until all awaited results are in
  } timer_cmd_t;

  typedef struct {
    status_t status;
    handle_t handle;
    logic    last;
    cnt_t    pending;
  } timer_result_t;

  logic clk;
  logic rst_n;

  dstq_in_if  in_chan ();
  dstq_out_if out_chan ();

  deadline_sorted_timer_queue dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  timer_cmd_t    cmd_q[$];
  timer_result_t awaited_results[$];

  // shadow copy of the timer queue
  time_t   shadow_dl[QUEUE_DEPTH];
  handle_t shadow_hd[QUEUE_DEPTH];
  int      shadow_cnt;

  int n_cmds;
  int n_taken;
  int err_cnt;
  int stall_cycles;
  bit in_taken;

  always #5 clk = ~clk;

  function automatic time_t rand_time();
    return time_t'({$urandom, $urandom});
  endfunction

  task automatic push_enqueue(input time_t dl, input handle_t hd);
    timer_cmd_t c;
    c = '{ACT_ENQUEUE, dl, hd, rand_time(), 1'b0};
    cmd_q.push_back(c);
  endtask

  task automatic push_tick(input time_t t);
    timer_cmd_t c;
    c = '{ACT_TICK, rand_time(), handle_t'($urandom), t, 1'b0};
    cmd_q.push_back(c);
  endtask

  // Insert or expire on the shadow queue and record the words it should produce
  task automatic run_timer_queue(input timer_cmd_t c);
    timer_result_t r;
    int slot;
    int due;
    if (c.action == ACT_ENQUEUE) begin
      if (shadow_cnt >= QUEUE_DEPTH) begin
        r = '{ST_FULL, '0, 1'b1, cnt_t'(shadow_cnt)};
      end else begin
        // equal deadlines keep arrival order
        slot = 0;
        while (slot < shadow_cnt && shadow_dl[slot] <= c.deadline) slot++;
        for (int i = shadow_cnt; i > slot; i--) begin
          shadow_dl[i] = shadow_dl[i-1];
          shadow_hd[i] = shadow_hd[i-1];
        end
        shadow_dl[slot] = c.deadline;
        shadow_hd[slot] = c.handle;
        shadow_cnt++;
        r = '{ST_ENQUEUED, '0, 1'b1, cnt_t'(shadow_cnt)};
      end
      awaited_results.push_back(r);
    end else begin
      // only deadlines strictly before the present time are due
      due = 0;
      while (due < shadow_cnt && shadow_dl[due] < c.at_time) due++;
      if (due == 0) begin
        r = '{ST_NONE_DUE, '0, 1'b1, cnt_t'(shadow_cnt)};
        awaited_results.push_back(r);
      end else begin
        for (int k = 0; k < due; k++) begin
          r = '{ST_FIRED, shadow_hd[k], logic'(k + 1 == due), cnt_t'(shadow_cnt - (k + 1))};
          awaited_results.push_back(r);
        end
        for (int k = due; k < shadow_cnt; k++) begin
          shadow_dl[k-due] = shadow_dl[k];
          shadow_hd[k-due] = shadow_hd[k];
        end
        shadow_cnt -= due;
      end
    end
  endtask

  // Sample both channels; check result words, predict from accepted input words
  always @(posedge clk) begin : monitor
    timer_result_t got;
    timer_result_t want;
    bit out_taken;
    in_taken  = rst_n && (in_chan.valid === 1'b1) && (in_chan.ready === 1'b1);
    out_taken = rst_n && (out_chan.valid === 1'b1) && (out_chan.ready === 1'b1);
    if (out_taken) begin
      got = '{out_chan.status, out_chan.fired_handle, out_chan.last, out_chan.pending_count};
      if (awaited_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected word: status %0d handle %h last %b pending %0d",
                 $time, got.status, got.handle, got.last, got.pending);
      end else begin
        want = awaited_results.pop_front();
        if (got.status !== want.status || got.handle !== want.handle ||
            got.last !== want.last || got.pending !== want.pending) begin
          err_cnt++;
          $display("%0t: mismatch: expected status %0d handle %h last %b pending %0d",
                   $time, want.status, want.handle, want.last, want.pending);
          $display("%0t:           actual   status %0d handle %h last %b pending %0d",
                   $time, got.status, got.handle, got.last, got.pending);
        end
      end
    end
    if (in_taken) begin
      run_timer_queue('{in_chan.action, in_chan.deadline, in_chan.handle,
                        in_chan.current_time, 1'b0});
      n_taken++;
    end
    if (in_taken || out_taken) stall_cycles = 0;
    else stall_cycles++;
  end

  // Present the next word once the previous one is taken; hold it while not
  always @(negedge clk) begin : driver
    bit send_now;
    bit quiet;
    timer_cmd_t c;
    quiet = (n_taken >= 100 && n_taken < 150);
    out_chan.ready <= rst_n && (quiet || $urandom_range(0, 99) >= 31);
    if (rst_n && (!in_chan.valid || in_taken)) begin
      send_now = 1'b0;
      if (cmd_q.size() != 0) begin
        if (cmd_q[0].hold) send_now = (awaited_results.size() == 0);
        else send_now = quiet || $urandom_range(0, 99) >= 31;
      end
      if (send_now) begin
        c = cmd_q.pop_front();
        in_chan.action       <= c.action;
        in_chan.deadline     <= c.deadline;
        in_chan.handle       <= c.handle;
        in_chan.current_time <= c.at_time;
      end
      in_chan.valid <= send_now;
    end
  end

  // Watchdog: give up when nothing moves for too long
  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) @(negedge clk);
    $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
    $display("tb_deadline_sorted_timer_queue: done, errors");
    $finish;
  end

  initial begin : stimulus
    time_t clock_us;
    time_t dl;
    int pick;
    clk                  = 1'b0;
    rst_n                = 1'b0;
    in_chan.valid        = 1'b0;
    in_chan.action       = ACT_ENQUEUE;
    in_chan.deadline     = '0;
    in_chan.handle       = '0;
    in_chan.current_time = '0;
    out_chan.ready       = 1'b0;
    shadow_cnt           = 0;
    n_taken              = 0;
    err_cnt              = 0;
    stall_cycles         = 0;
    in_taken             = 1'b0;

    // directed: empty tick, extremes, equal deadlines, deadline equal to present time
    push_tick('0);
    push_enqueue('0, '0);
    push_enqueue('1, '1);
    push_enqueue(time_t'(100), handle_t'(1));
    push_enqueue(time_t'(100), handle_t'(2));
    push_enqueue(time_t'(100), handle_t'(3));
    push_enqueue(time_t'(50), handle_t'(4));
    push_tick(time_t'(100));
    push_tick('1);
    // fill up with falling deadlines so each insert scans the whole queue
    for (int i = 0; i < QUEUE_DEPTH - 1; i++)
      push_enqueue(time_t'(1000 - i), handle_t'(16'h1000 + i));
    push_enqueue(time_t'(7), handle_t'(16'h00ff));
    push_tick('1);
    push_tick('0);

    // random: deadlines clustered round a moving clock, with jumps and wild values
    clock_us = rand_time();
    for (int i = 0; i < N_RANDOM; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) clock_us = rand_time();
      if (pick < 62) begin
        if ($urandom_range(0, 9) == 0) dl = rand_time();
        else dl = clock_us + time_t'($urandom_range(0, 60));
        push_enqueue(dl, handle_t'($urandom));
      end else begin
        clock_us = clock_us + time_t'($urandom_range(0, 25));
        if ($urandom_range(0, 9) == 0) push_tick(rand_time());
        else push_tick(clock_us);
      end
      if (i == 0 || $urandom_range(0, 49) == 0) cmd_q[cmd_q.size()-1].hold = 1'b1;
    end
    n_cmds = cmd_q.size();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // drain, then allow for any word still on its way
    while (n_taken < n_cmds || awaited_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (err_cnt == 0 && awaited_results.size() == 0)
      $display("tb_deadline_sorted_timer_queue: done, clean");
    else
      $display("tb_deadline_sorted_timer_queue: done, errors");
    $finish;
  end

endmodule
